// ===== rtl/bellman_ford_shortest_paths_macros.svh =====
// assertion macros shared by the shortest path block
`ifndef BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define BFSP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define BFSP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bfsp_pkg.sv =====
// types and constants of the shortest path block
package bfsp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int VTX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int DIST_W = 32;
  localparam int WIN_W  = 16;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic signed [DIST_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DIST_W-1:0] INT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [VTX_W-1:0]        src_vertex;
    logic [VTX_W-1:0]        dst_vertex;
    logic signed [WIN_W-1:0] edge_weight;
  } bfsp_in_t;

  typedef struct packed {
    logic [VTX_W-1:0]         vertex_index;
    logic signed [DIST_W-1:0] distance;
    logic                     reached;
    logic                     neg_cycle;
    logic                     last;
  } bfsp_out_t;

  // run command from the request decoder to the sequencer
  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] num_vertices;
  } bfsp_cmd_t;

endpackage

// ===== rtl/bfsp_ram.sv =====
// generic single write port ram with registered read
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bfsp_ctrl.sv =====
// run sequencer: relaxation passes, check pass and result emission
`include "bellman_ford_shortest_paths_macros.svh"

module bfsp_ctrl #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF,
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int ECW = $clog2(MAX_EDGES + 1),
  localparam int EW  = 2 * bfsp_pkg::VTX_W + WEIGHT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfsp_pkg::bfsp_cmd_t cmd_i,
  input  logic [ECW-1:0]      edge_cnt_i,
  output logic                edge_re_o,
  output logic [EAW-1:0]      edge_raddr_o,
  input  logic [EW-1:0]       edge_rdata_i,
  output logic                busy_o,
  output logic                res_valid_o,
  output bfsp_pkg::bfsp_out_t res_o
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int DW  = bfsp_pkg::DIST_W;
  localparam int CW  = bfsp_pkg::CFG_W;
  localparam int VW  = bfsp_pkg::VTX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_DREAD, S_EVAL, S_RES, S_ORD, S_OWR
  } state_e;

  state_e                  state_q;
  logic [EAW-1:0]          j_q;
  logic [CW-1:0]           pass_q;
  logic                    chk_q;
  logic                    any_q;
  logic [CW-1:0]           nv_q;
  logic [VAW-1:0]          idx_q;
  logic [MAX_VERTICES-1:0] reached_q;
  logic                    res_valid_q;
  bfsp_pkg::bfsp_out_t     res_q;

  logic [VW-1:0]          e_src;
  logic [VW-1:0]          e_dst;
  logic [WEIGHT_BITS-1:0] e_w;
  logic signed [DW-1:0]   dist_a;
  logic signed [DW-1:0]   dist_b;
  logic signed [DW:0]     sum;
  logic signed [DW-1:0]   sat;
  logic                   src_reached;
  logic                   dst_reached;
  logic                   edge_live;
  logic                   relax_apply;
  logic                   relax_chk;
  logic                   last_edge;
  logic [EAW-1:0]         j_nxt;
  logic                   dist_re;
  logic [VAW-1:0]         dist_raddr_a;
  logic                   init_we;
  logic                   dist_we;
  logic [VAW-1:0]         dist_waddr;
  logic signed [DW-1:0]   dist_wdata;

  assign e_src = edge_rdata_i[EW-1 -: VW];
  assign e_dst = edge_rdata_i[EW-1-VW -: VW];
  assign e_w   = edge_rdata_i[WEIGHT_BITS-1:0];

  assign src_reached = reached_q[e_src[VAW-1:0]];
  assign dst_reached = reached_q[e_dst[VAW-1:0]];
  assign edge_live   = (CW'(e_src) < nv_q) && (CW'(e_dst) < nv_q) && src_reached;

  // exact sum, saturated for the relaxation compare and the stored value
  assign sum = (DW+1)'(dist_a) + (DW+1)'($signed(e_w));
  always_comb begin
    if (sum[DW] != sum[DW-1]) begin
      sat = sum[DW] ? bfsp_pkg::INT_MIN : bfsp_pkg::INT_MAX;
    end else begin
      sat = sum[DW-1:0];
    end
  end

  assign relax_apply = edge_live && (!dst_reached || (sat < dist_b));
  assign relax_chk   = edge_live && (!dst_reached || (sum < (DW+1)'(dist_b)));

  assign last_edge = (ECW'(j_q) + ECW'(1)) == edge_cnt_i;
  assign j_nxt     = last_edge ? '0 : j_q + EAW'(1);

  // next edge is fetched while the current one is evaluated
  assign edge_re_o    = (state_q == S_FETCH) || (state_q == S_EVAL);
  assign edge_raddr_o = (state_q == S_EVAL) ? j_nxt : j_q;

  // the source distance is set to zero when a run starts
  assign init_we      = (state_q == S_IDLE) && cmd_i.start;
  assign dist_re      = (state_q == S_DREAD) || (state_q == S_ORD);
  assign dist_raddr_a = (state_q == S_ORD) ? idx_q : e_src[VAW-1:0];
  assign dist_we      = ((state_q == S_EVAL) && !chk_q && relax_apply) || init_we;
  assign dist_waddr   = init_we ? '0 : e_dst[VAW-1:0];
  assign dist_wdata   = init_we ? '0 : sat;

  // two copies give the start and end distance of an edge in one read
  bfsp_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VERTICES)
  ) u_dist_a (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_re),
    .raddr_i (dist_raddr_a),
    .rdata_o (dist_a)
  );

  bfsp_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_VERTICES)
  ) u_dist_b (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_re),
    .raddr_i (e_dst[VAW-1:0]),
    .rdata_o (dist_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      j_q         <= '0;
      pass_q      <= '0;
      chk_q       <= 1'b0;
      any_q       <= 1'b0;
      nv_q        <= '0;
      idx_q       <= '0;
      reached_q   <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_i.start) begin
            nv_q      <= cmd_i.num_vertices;
            reached_q <= MAX_VERTICES'(1);
            j_q       <= '0;
            pass_q    <= CW'(1);
            chk_q     <= (cmd_i.num_vertices == CW'(1));
            any_q     <= 1'b0;
            state_q   <= (edge_cnt_i == '0) ? S_RES : S_FETCH;
          end
        end
        S_FETCH: state_q <= S_DREAD;
        S_DREAD: state_q <= S_EVAL;
        S_EVAL: begin
          if (chk_q && relax_chk) begin
            any_q <= 1'b1;
          end
          if (dist_we) begin
            reached_q[e_dst[VAW-1:0]] <= 1'b1;
          end
          j_q     <= j_nxt;
          state_q <= S_DREAD;
          if (last_edge) begin
            if (chk_q) begin
              state_q <= S_RES;
            end else if (pass_q + CW'(1) == nv_q) begin
              chk_q <= 1'b1;
            end else begin
              pass_q <= pass_q + CW'(1);
            end
          end
        end
        S_RES: begin
          if (any_q) begin
            res_q.vertex_index <= '0;
            res_q.distance     <= '0;
            res_q.reached      <= 1'b0;
            res_q.neg_cycle    <= 1'b1;
            res_q.last         <= 1'b1;
            res_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end else begin
            idx_q   <= '0;
            state_q <= S_ORD;
          end
        end
        S_ORD: state_q <= S_OWR;
        S_OWR: begin
          res_q.vertex_index <= VW'(idx_q);
          res_q.distance     <= reached_q[idx_q] ? dist_a : '0;
          res_q.reached      <= reached_q[idx_q];
          res_q.neg_cycle    <= 1'b0;
          res_q.last         <= (CW'(idx_q) + CW'(1)) == nv_q;
          res_valid_q        <= 1'b1;
          idx_q              <= idx_q + VAW'(1);
          state_q            <= ((CW'(idx_q) + CW'(1)) == nv_q) ? S_IDLE : S_ORD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `BFSP_ASSERT_NXT(a_start_busy, cmd_i.start, state_q != S_IDLE, "run start did not leave idle")
  `BFSP_ASSERT_IMP(a_more_follow, res_valid_q && !res_q.last, state_q == S_ORD, "vertex results stopped before last")
  `BFSP_ASSERT_IMP(a_neg_alone, res_valid_q && res_q.neg_cycle, res_q.last && (res_q.vertex_index == '0), "negative cycle result not single")
  `BFSP_ASSERT_IMP(a_chk_no_write, (state_q == S_EVAL) && chk_q, !dist_we, "distance written during check pass")

endmodule

// ===== rtl/bellman_ford_shortest_paths.sv =====
// top level: request decode, edge store, vertex count register, run sequencer
//
// One command channel: a request transfers at a rising edge with start high and
// busy low. Load appends an edge (ignored once the store is full) and clear
// empties the store; both give no result and keep busy low.
// A run raises busy from the next cycle; busy drops in the cycle that shows the
// last result. Results leave on res_o, each for one cycle with res_valid_o
// high; the receiver takes every result and cannot stall the block.
// Run steps with E stored edges and N vertices in use: a first edge fetch, N - 1
//   relaxation passes and one check pass (per edge a distance read, then add,
//   compare and write back on the distance memory), a result decision, then
//   a distance read and emission per vertex, or one negative cycle result.
// With an empty store a run goes straight to emission.
// The vertex count is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, which the block does not enforce. Zero acts as one
// and values above the vertex limit act as the limit.
// Reset: vertex count 64, edge store empty, sequencer idle, no result shown.
// The edge and distance memories need no clearing pass after reset.
module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  bfsp_pkg::bfsp_in_t           req_i,
  input  logic                         cfg_we_i,
  input  logic [bfsp_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                         res_valid_o,
  output bfsp_pkg::bfsp_out_t          res_o
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int EW  = 2 * bfsp_pkg::VTX_W + WEIGHT_BITS;
  localparam int CW  = bfsp_pkg::CFG_W;

  logic [CW-1:0]       nv_q;
  logic [CW-1:0]       nv_eff;
  logic [ECW-1:0]      count_q;
  logic                accept;
  logic                edge_we;
  logic [EW-1:0]       edge_wdata;
  logic                edge_re;
  logic [EAW-1:0]      edge_raddr;
  logic [EW-1:0]       edge_rdata;
  logic                busy_int;
  bfsp_pkg::bfsp_cmd_t cmd;

  assign accept = start && !busy_int;

  always_comb begin
    if (nv_q == '0) begin
      nv_eff = CW'(1);
    end else if (nv_q > CW'(MAX_VERTICES)) begin
      nv_eff = CW'(MAX_VERTICES);
    end else begin
      nv_eff = nv_q;
    end
  end

  assign edge_we    = accept && (req_i.req_type == bfsp_pkg::REQ_LOAD) &&
                      (count_q != ECW'(MAX_EDGES));
  assign edge_wdata = {req_i.src_vertex, req_i.dst_vertex,
                       WEIGHT_BITS'($unsigned(req_i.edge_weight))};

  assign cmd.start        = accept && (req_i.req_type == bfsp_pkg::REQ_RUN);
  assign cmd.num_vertices = nv_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q    <= CW'(64);
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        nv_q <= cfg_wdata_i;
      end
      if (accept) begin
        case (req_i.req_type)
          bfsp_pkg::REQ_LOAD: begin
            if (edge_we) begin
              count_q <= count_q + ECW'(1);
            end
          end
          bfsp_pkg::REQ_CLEAR: count_q <= '0;
          default: ;
        endcase
      end
    end
  end

  bfsp_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (count_q[EAW-1:0]),
    .wdata_i (edge_wdata),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  bfsp_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .edge_cnt_i   (count_q),
    .edge_re_o    (edge_re),
    .edge_raddr_o (edge_raddr),
    .edge_rdata_i (edge_rdata),
    .busy_o       (busy_int),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  assign busy = busy_int;

endmodule

// ===== tb/sv/bfsp_path_checker.sv =====
// checker for the shortest path block: tracks edges and vertex count, predicts, compares
`timescale 1ns / 1ps

module bfsp_path_checker #(
  parameter int EDGE_MAX = bfsp_pkg::MAX_EDGES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  bfsp_pkg::bfsp_in_t         req_i,
  input  logic                       cfg_we_i,
  input  logic [bfsp_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       res_valid_i,
  input  bfsp_pkg::bfsp_out_t        res_i,
  output int                         err_cnt_o,
  output int                         pending_o,
  output int                         checked_o
);

  localparam int NV_MAX = bfsp_pkg::MAX_VERTICES_DEF;

  logic [bfsp_pkg::CFG_W-1:0]        vtx_cfg;
  logic [bfsp_pkg::VTX_W-1:0]        e_src [EDGE_MAX];
  logic [bfsp_pkg::VTX_W-1:0]        e_dst [EDGE_MAX];
  logic signed [bfsp_pkg::WIN_W-1:0] e_wt  [EDGE_MAX];
  int                                e_cnt;
  bfsp_pkg::bfsp_out_t               path_q [$];

  // exact sums, saturated on store; the check pass compares the exact sum
  function automatic void predict_paths(input int nv);
    logic signed [bfsp_pkg::DIST_W-1:0] dist_v [NV_MAX];
    bit                                 reach  [NV_MAX];
    longint                             sum;
    logic signed [bfsp_pkg::DIST_W-1:0] sat;
    bit                                 neg;
    int                                 a;
    int                                 b;
    bfsp_pkg::bfsp_out_t                r;
    for (int i = 0; i < NV_MAX; i++) begin
      dist_v[i] = '0;
      reach[i]  = 1'b0;
    end
    reach[0] = 1'b1;
    for (int p = 1; p < nv; p++) begin
      for (int j = 0; j < e_cnt; j++) begin
        a = int'(e_src[j]);
        b = int'(e_dst[j]);
        if (a >= nv || b >= nv || !reach[a]) continue;
        sum = longint'(dist_v[a]) + longint'(e_wt[j]);
        if (sum > longint'(bfsp_pkg::INT_MAX)) sat = bfsp_pkg::INT_MAX;
        else if (sum < longint'(bfsp_pkg::INT_MIN)) sat = bfsp_pkg::INT_MIN;
        else sat = bfsp_pkg::DIST_W'(sum);
        if (!reach[b] || sat < dist_v[b]) begin
          dist_v[b] = sat;
          reach[b]  = 1'b1;
        end
      end
    end
    neg = 1'b0;
    for (int j = 0; j < e_cnt; j++) begin
      a = int'(e_src[j]);
      b = int'(e_dst[j]);
      if (a >= nv || b >= nv || !reach[a]) continue;
      sum = longint'(dist_v[a]) + longint'(e_wt[j]);
      if (!reach[b] || sum < longint'(dist_v[b])) neg = 1'b1;
    end
    if (neg) begin
      r = '0;
      r.neg_cycle = 1'b1;
      r.last      = 1'b1;
      path_q = {path_q, r};
    end else begin
      for (int i = 0; i < nv; i++) begin
        r.vertex_index = bfsp_pkg::VTX_W'(i);
        r.distance     = reach[i] ? dist_v[i] : '0;
        r.reached      = reach[i];
        r.neg_cycle    = 1'b0;
        r.last         = (i + 1 == nv);
        path_q = {path_q, r};
      end
    end
  endfunction

  function automatic bit field_bad(input string fld, input longint exp_v, input longint act_v);
    if (exp_v == act_v) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_v, act_v);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bfsp_pkg::bfsp_out_t exp_r;
    bit                  bad;
    int                  nv;
    if (!rst_ni) begin
      vtx_cfg   = bfsp_pkg::CFG_W'(NV_MAX);
      e_cnt     = 0;
      path_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (res_valid_i === 1'b1) begin
        if (path_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected result, vertex %0d distance %0d reached %0b neg %0b last %0b",
                   $time, res_i.vertex_index, res_i.distance, res_i.reached,
                   res_i.neg_cycle, res_i.last);
        end else begin
          exp_r = path_q.pop_front();
          checked_o++;
          bad = 1'b0;
          bad |= field_bad("vertex_index", longint'(exp_r.vertex_index),
                           longint'(res_i.vertex_index));
          bad |= field_bad("distance", longint'(exp_r.distance), longint'(res_i.distance));
          bad |= field_bad("reached", longint'(exp_r.reached), longint'(res_i.reached));
          bad |= field_bad("neg_cycle", longint'(exp_r.neg_cycle), longint'(res_i.neg_cycle));
          bad |= field_bad("last", longint'(exp_r.last), longint'(res_i.last));
          // an x or z field slips through the integer compares
          if (!bad && res_i !== exp_r) begin
            bad = 1'b1;
            $display("%0t: unknown bits in result, expected %h, actual %h", $time, exp_r, res_i);
          end
          if (bad) err_cnt_o++;
        end
      end
      if (cfg_we_i) vtx_cfg = cfg_wdata_i;
      if (start_i && !busy_i) begin
        case (req_i.req_type)
          bfsp_pkg::REQ_LOAD: begin
            if (e_cnt < EDGE_MAX) begin
              e_src[e_cnt] = req_i.src_vertex;
              e_dst[e_cnt] = req_i.dst_vertex;
              e_wt[e_cnt]  = req_i.edge_weight;
              e_cnt++;
            end
          end
          bfsp_pkg::REQ_RUN: begin
            nv = int'(vtx_cfg);
            if (nv < 1) nv = 1;
            if (nv > NV_MAX) nv = NV_MAX;
            predict_paths(nv);
          end
          bfsp_pkg::REQ_CLEAR: e_cnt = 0;
          default: ;
        endcase
      end
      pending_o = path_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench top: clock, reset, request and vertex count stimulus, verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int         LIMIT     = 2_000_000;
  // a small edge store keeps the full-store case short
  localparam int         TB_EDGES  = 16;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  bfsp_pkg::bfsp_in_t         req;
  logic                       cfg_we;
  logic [bfsp_pkg::CFG_W-1:0] cfg_wdata;
  logic                       res_valid;
  bfsp_pkg::bfsp_out_t        res;

  int err_cnt;
  int pending;
  int checked;
  int cycles;
  int n_items;
  int n_runs;
  int n_cfg;
  int idle_pct;
  int stored;

  bellman_ford_shortest_paths #(
    .MAX_EDGES (TB_EDGES)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bfsp_path_checker #(
    .EDGE_MAX (TB_EDGES)
  ) chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .res_valid_i (res_valid),
    .res_i       (res),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic bfsp_pkg::bfsp_in_t mk(input logic [1:0] t, input int s, input int d,
                                            input int w);
    bfsp_pkg::bfsp_in_t r;
    r.req_type    = t;
    r.src_vertex  = bfsp_pkg::VTX_W'(s);
    r.dst_vertex  = bfsp_pkg::VTX_W'(d);
    r.edge_weight = bfsp_pkg::WIN_W'(w);
    return r;
  endfunction

  function automatic int clamp_nv(input int v);
    if (v < 1) return 1;
    if (v > bfsp_pkg::MAX_VERTICES_DEF) return bfsp_pkg::MAX_VERTICES_DEF;
    return v;
  endfunction

  // mostly edges among the vertices in use, now and then one outside them
  function automatic bfsp_pkg::bfsp_in_t make_edge(input int nv);
    bfsp_pkg::bfsp_in_t r;
    int                 sel;
    r.req_type   = bfsp_pkg::REQ_LOAD;
    r.src_vertex = ($urandom_range(0, 9) == 0) ? bfsp_pkg::VTX_W'($urandom) :
                   bfsp_pkg::VTX_W'($urandom_range(0, nv - 1));
    r.dst_vertex = ($urandom_range(0, 9) == 0) ? bfsp_pkg::VTX_W'($urandom) :
                   bfsp_pkg::VTX_W'($urandom_range(0, nv - 1));
    sel = $urandom_range(0, 19);
    if (sel < 12) r.edge_weight = bfsp_pkg::WIN_W'($urandom_range(0, 200));
    else if (sel < 17) r.edge_weight = bfsp_pkg::WIN_W'(0 - int'($urandom_range(1, 50)));
    else r.edge_weight = bfsp_pkg::WIN_W'($urandom);
    return r;
  endfunction

  // one transfer; start stays high unless an idle gap follows
  task automatic send_req(input bfsp_pkg::bfsp_in_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    n_items++;
    if (r.req_type == bfsp_pkg::REQ_RUN) n_runs++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      req   <= bfsp_pkg::bfsp_in_t'(30'($urandom));
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_vertices(input int v);
    wait_idle();
    // loads may still be settling even with nothing outstanding
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bfsp_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_round();
    int v;
    int nv;
    int k;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = 0;
      1: v = 1;
      2: v = bfsp_pkg::MAX_VERTICES_DEF;
      3: v = (1 << bfsp_pkg::CFG_W) - 1;
      4: v = $urandom_range(bfsp_pkg::MAX_VERTICES_DEF + 1, (1 << bfsp_pkg::CFG_W) - 1);
      default: v = $urandom_range(2, 12);
    endcase
    write_vertices(v);
    nv = clamp_nv(v);
    if (stored > 40 || $urandom_range(0, 2) == 0) begin
      send_req(mk(bfsp_pkg::REQ_CLEAR, $urandom, $urandom, $urandom));
      stored = 0;
    end
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 8);
    repeat (k) begin
      if ($urandom_range(0, 19) == 0) begin
        send_req(mk(REQ_SPARE, $urandom, $urandom, $urandom));
      end else begin
        send_req(make_edge(nv));
        stored++;
      end
    end
    send_req(mk(bfsp_pkg::REQ_RUN, $urandom, $urandom, $urandom));
  endtask

  initial begin
    int phase_start;
    rst_n     = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    n_items   = 0;
    n_runs    = 0;
    n_cfg     = 0;
    stored    = 0;
    idle_pct  = 9;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store at the reset vertex count
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));
    // zero vertex count acts as one
    write_vertices(0);
    send_req(mk(bfsp_pkg::REQ_RUN, 63, 63, -1));
    write_vertices(5);
    send_req(mk(bfsp_pkg::REQ_LOAD, 0, 1, 32767));
    send_req(mk(bfsp_pkg::REQ_LOAD, 1, 2, -32768));
    send_req(mk(bfsp_pkg::REQ_LOAD, 2, 3, 5));
    send_req(mk(bfsp_pkg::REQ_LOAD, 0, 3, -40));
    // edges touching vertices outside the ones in use
    send_req(mk(bfsp_pkg::REQ_LOAD, 4, 63, 1));
    send_req(mk(bfsp_pkg::REQ_LOAD, 63, 0, -7));
    send_req(mk(REQ_SPARE, 63, 63, -1));
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));
    // reachable negative loop
    send_req(mk(bfsp_pkg::REQ_LOAD, 3, 4, -1));
    send_req(mk(bfsp_pkg::REQ_LOAD, 4, 3, -1));
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));
    send_req(mk(bfsp_pkg::REQ_CLEAR, 0, 0, 0));
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));
    // count above the limit acts as the limit
    write_vertices((1 << bfsp_pkg::CFG_W) - 1);
    send_req(mk(bfsp_pkg::REQ_LOAD, 0, 63, -32768));
    send_req(mk(bfsp_pkg::REQ_LOAD, 63, 62, 32767));
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));
    write_vertices(1);
    send_req(mk(bfsp_pkg::REQ_LOAD, 0, 0, 0));
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));

    // fill the store past its depth, extra loads are dropped
    write_vertices(3);
    send_req(mk(bfsp_pkg::REQ_CLEAR, 0, 0, 0));
    repeat (TB_EDGES + 4)
      send_req(mk(bfsp_pkg::REQ_LOAD, $urandom_range(0, 2), $urandom_range(0, 2),
                  $urandom_range(0, 1000)));
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));
    write_vertices(bfsp_pkg::MAX_VERTICES_DEF);
    send_req(mk(bfsp_pkg::REQ_RUN, 0, 0, 0));
    send_req(mk(bfsp_pkg::REQ_CLEAR, 0, 0, 0));
    stored = 0;

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 9 : (ph == 1) ? 72 : 0;
      phase_start = n_items;
      while (n_items - phase_start < 20) random_round();
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("sent %0d requests (%0d runs, %0d vertex count writes), %0d results checked",
             n_items, n_runs, n_cfg, checked);
    $display("covered empty and full stores, clamped counts, off-range edges, negative loops");
    if (err_cnt == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
